>>> design/sbrq_pkg.sv
// Shared types and constants for the shuffled batch release queue.
package sbrq_pkg;

  localparam int unsigned StatusW = 2;

  typedef enum logic [1:0] {
    MODE_ENQ   = 2'd0,
    MODE_POLL  = 2'd1,
    MODE_REL   = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic CFG_BATCH_LIMIT = 1'b0;
  localparam logic CFG_WAIT_LIMIT  = 1'b1;

  // in tdata: mode[1:0] handle[65:2] port[81:66] now[113:82] seed[145:114], pad to 152
  localparam int unsigned InW  = 152;
  // out tdata: status[1:0] due[2] handle[66:3] port[82:67] count[87:83]
  //   enq[119:88] rej[151:120] rel[183:152], pad to 184
  localparam int unsigned OutW = 184;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

>>> design/shuffled_batch_release_queue.sv
// Shuffled batch release queue: top level.
// Each transaction is handled alone. For enqueue and poll the result is valid
// the cycle after acceptance and the next input is taken the cycle after the
// result is taken. A release of n frames shuffles in place in the slot RAM:
// each of the n-1 swaps steps the xorshift generator, runs a bit-serial
// remainder and then two RAM reads and two writes, after which the frames are
// read out one at a time, each held until taken. The slot RAM has no clearing
// pass; only written slots are read.
module shuffled_batch_release_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // mode, frame_handle, hop_port, now_ms, random_seed
  input  logic [sbrq_pkg::InW-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status, release_due, out_handle, out_port, queued_count,
  // enqueued_total, rejected_total, released_total
  output logic [sbrq_pkg::OutW-1:0]   m_axis_tdata,
  output logic                        m_axis_tlast,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [31:0]                 cfg_data
);
  import sbrq_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MOD   = 10'b0000000010,
    S_RDI   = 10'b0000000100,
    S_RDJ   = 10'b0000001000,
    S_WRI   = 10'b0000010000,
    S_WRJ   = 10'b0000100000,
    S_OUTRD = 10'b0001000000,
    S_OUTW  = 10'b0010000000,
    S_ONE   = 10'b0100000000,
    S_STEP  = 10'b1000000000
  } state_t;

  state_t state;
  logic [4:0]  batch_limit;
  logic [31:0] wait_limit_ms;
  logic [CW-1:0] held_count;
  logic [31:0] first_arrival, acc_cnt, rej_cnt, drn_cnt, rng;
  logic [CW-1:0] n_drain, idx;
  logic [AW-1:0] jdx;
  logic [79:0] ent_i, ent_j;

  logic [1:0]  in_mode;
  logic [63:0] in_handle;
  logic [15:0] in_port;
  logic [31:0] in_now, in_seed;
  assign in_mode   = s_axis_tdata[1:0];
  assign in_handle = s_axis_tdata[65:2];
  assign in_port   = s_axis_tdata[81:66];
  assign in_now    = s_axis_tdata[113:82];
  assign in_seed   = s_axis_tdata[145:114];

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [79:0]   wdata, rdata;
  sbrq_ram #(.WIDTH(80), .DEPTH(SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // remainder unit
  logic          mod_start, mod_done;
  logic [CW-1:0] mod_rem;
  sbrq_modu #(.DW(CW)) u_mod (
    .clk, .rst, .start(mod_start), .dividend(rng), .divisor(idx + CW'(1)),
    .done(mod_done), .remainder(mod_rem)
  );

  logic [CW-1:0] eff_limit;
  always_comb begin
    if (batch_limit == 5'd0) eff_limit = CW'(1);
    else if ({27'd0, batch_limit} > 32'(SLOTS)) eff_limit = SlotsC;
    else eff_limit = CW'(batch_limit);
  end

  function automatic logic due_f(input logic [CW-1:0] cnt, input logic [CW-1:0] lim,
                                 input logic [31:0] now, input logic [31:0] fa,
                                 input logic [31:0] wl);
    if (cnt == '0) return 1'b0;
    if (cnt >= lim) return 1'b1;
    return (now - fa) >= wl;
  endfunction

  logic in_fire, out_fire;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  logic [1:0]  o_status;
  logic        o_due;
  logic [79:0] o_ent;
  assign m_axis_tdata = {drn_cnt, rej_cnt, acc_cnt,
                         5'(held_count), o_ent[15:0], o_ent[79:16], o_due, o_status};

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx[AW-1:0];
    mod_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire && in_mode == MODE_ENQ && held_count < eff_limit
            && held_count < SlotsC) begin
          we = 1'b1; waddr = held_count[AW-1:0]; wdata = {in_handle, in_port};
        end
      end
      S_STEP:  mod_start = 1'b1;
      S_MOD:   raddr = idx[AW-1:0];
      S_RDI:   raddr = jdx;
      S_RDJ:   raddr = jdx;
      S_WRI:   begin we = 1'b1; waddr = idx[AW-1:0]; wdata = ent_j; end
      S_WRJ:   begin we = 1'b1; waddr = jdx; wdata = ent_i; end
      S_OUTRD: raddr = idx[AW-1:0];
      S_OUTW:  raddr = idx[AW-1:0];
      S_ONE:   raddr = idx[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      batch_limit <= 5'd8;
      wait_limit_ms <= 32'd250;
      held_count <= '0;
      first_arrival <= '0;
      acc_cnt <= '0; rej_cnt <= '0; drn_cnt <= '0;
      rng <= 32'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BATCH_LIMIT) batch_limit <= cfg_data[4:0];
        else wait_limit_ms <= cfg_data;
      end
      // S_OUTW reloads the output itself when the held result is taken
      if (out_fire && state != S_OUTW) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            o_ent <= '0; m_axis_tlast <= 1'b1;
            unique case (in_mode)
              MODE_ENQ: begin
                if (held_count >= eff_limit || held_count >= SlotsC) begin
                  rej_cnt <= rej_cnt + 32'd1; o_status <= ST_FULL;
                  o_due <= due_f(held_count, eff_limit, in_now, first_arrival,
                                 wait_limit_ms);
                end else begin
                  o_status <= ST_OK;
                  held_count <= held_count + CW'(1);
                  acc_cnt <= acc_cnt + 32'd1;
                  if (held_count == '0) first_arrival <= in_now;
                  o_due <= due_f(held_count + CW'(1), eff_limit, in_now,
                                 (held_count == '0) ? in_now : first_arrival,
                                 wait_limit_ms);
                end
                m_axis_tvalid <= 1'b1;
              end
              MODE_POLL: begin
                o_status <= ST_OK;
                o_due <= due_f(held_count, eff_limit, in_now, first_arrival,
                               wait_limit_ms);
                m_axis_tvalid <= 1'b1;
              end
              default: begin
                if (held_count == '0) begin
                  if (in_mode == MODE_FLUSH) first_arrival <= '0;
                  o_status <= ST_EMPTY; o_due <= 1'b0;
                  m_axis_tvalid <= 1'b1;
                end else begin
                  o_status <= ST_OK;
                  n_drain <= held_count;
                  idx <= held_count - CW'(1);
                  drn_cnt <= drn_cnt + 32'(held_count);
                  held_count <= '0;
                  first_arrival <= '0;
                  rng <= (in_seed == '0) ? 32'd1 : in_seed;
                  o_due <= 1'b0;
                  if (held_count == CW'(1)) state <= S_OUTRD;
                  else state <= S_ONE;
                end
              end
            endcase
          end
        end
        S_ONE: begin
          rng <= xorshift32(rng);
          state <= S_STEP;
        end
        S_STEP: state <= S_MOD;
        S_MOD: begin
          if (mod_done) begin
            jdx <= mod_rem[AW-1:0];
            state <= S_RDI;
          end
        end
        // entry i was read while waiting in S_MOD; entry j is read here
        S_RDI: begin
          ent_i <= rdata;
          state <= S_RDJ;
        end
        S_RDJ: begin
          ent_j <= rdata;
          state <= S_WRI;
        end
        S_WRI: state <= S_WRJ;
        S_WRJ: begin
          if (idx == CW'(1)) begin
            idx <= '0;
            state <= S_OUTRD;
          end else begin
            idx <= idx - CW'(1);
            state <= S_ONE;
          end
        end
        S_OUTRD: state <= S_OUTW;
        S_OUTW: begin
          if (!m_axis_tvalid || out_fire) begin
            o_ent <= rdata;
            m_axis_tvalid <= 1'b1;
            m_axis_tlast <= (idx + CW'(1) == n_drain);
            if (idx + CW'(1) == n_drain) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
              state <= S_OUTRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/sbrq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sbrq_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/sbrq_modu.sv
// Iterative 32-bit by small-divisor remainder, one quotient bit a cycle.
module sbrq_modu #(
  parameter int unsigned DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);
  logic [31:0] shreg;
  logic [DW:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [DW+1:0] trial;

  always_comb begin
    trial = {rem, shreg[31]} - {2'b00, divisor};
  end

  assign remainder = rem[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        shreg <= dividend;
        rem  <= '0;
      end else if (busy) begin
        shreg <= shreg << 1;
        if (!trial[DW+1]) begin
          rem <= trial[DW:0];
        end else begin
          rem <= {rem[DW-1:0], shreg[31]};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
